FILE: src/fmv_pkg.sv
// Shared constants, payload structs and control types for the forest classifier.
`timescale 1ns / 1ps
`default_nettype none
package fmv_pkg;

	localparam int MAX_TREES      = 16;
	localparam int NODES_PER_TREE = 1024;
	localparam int NUM_FEATURES   = 8;
	localparam int NUM_CLASSES    = 16;
	localparam int MAX_DEPTH      = 32;

	localparam int TREE_W      = $clog2(MAX_TREES);
	localparam int NODE_W      = $clog2(NODES_PER_TREE);
	localparam int FEAT_W      = $clog2(NUM_FEATURES);
	localparam int LABEL_W     = $clog2(NUM_CLASSES);
	localparam int CNT_W       = $clog2(MAX_TREES + 1);
	localparam int STEP_W      = $clog2(MAX_DEPTH + 1);
	localparam int ADDR_W      = TREE_W + NODE_W;
	localparam int TABLE_DEPTH = MAX_TREES * NODES_PER_TREE;
	localparam int ACTION_W    = 2;
	localparam int VALUE_W     = 32;
	localparam int CFG_W       = 5;
	localparam int VOTES_W     = 5;

	localparam logic [CFG_W-1:0] TREES_RESET = 5'd15;

	localparam logic [ACTION_W-1:0] ACT_NODE_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FEAT_WRITE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLASSIFY   = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [TREE_W-1:0]         tree_index;
		logic [NODE_W-1:0]         node_index;
		logic [FEAT_W-1:0]         feature_index;
		logic signed [VALUE_W-1:0] value;
		logic                      is_leaf;
		logic [LABEL_W-1:0]        class_label;
		logic [NODE_W-1:0]         left_index;
		logic [NODE_W-1:0]         right_index;
	} fmv_in_t;

	typedef struct packed {
		logic [LABEL_W-1:0] predicted_label;
		logic [VOTES_W-1:0] winning_votes;
		logic               walk_error;
	} fmv_out_t;

	typedef struct packed {
		logic [FEAT_W-1:0]         feature_index;
		logic signed [VALUE_W-1:0] threshold;
		logic                      is_leaf;
		logic [LABEL_W-1:0]        class_label;
		logic [NODE_W-1:0]         left_index;
		logic [NODE_W-1:0]         right_index;
	} fmv_node_t;

	localparam int NODE_BITS = $bits(fmv_node_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} fmv_state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_CHILD,
		SEL_NEXT_ROOT
	} fmv_addr_sel_t;

	typedef struct packed {
		logic          node_we;
		logic          feat_we;
		logic          init;
		logic          step;
		logic          tree_done;
		logic          finish;
		fmv_addr_sel_t addr_sel;
	} fmv_cmd_t;

	typedef struct packed {
		logic no_trees;
		logic node_leaf;
		logic depth_hit;
		logic last_tree;
	} fmv_status_t;

endpackage
`default_nettype wire

FILE: src/forest_majority_vote_classifier_top.sv
// Top level of the decision-forest majority-vote classifier.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------
//  input    | start & !busy           | item   (fmv_in_t)
//  config   | cfg_we                  | cfg_wdata (trees in use)
//  result   | done (one-cycle strobe) | result (fmv_out_t)
//
// Node and feature writes never raise busy.
// A classify holds busy while it walks the node table (its single read port
// visits one node a cycle, at most 33 per tree) and while it closes the vote;
// done follows in the next cycle.
// With zero trees in use a classify goes straight to closing the vote and reports label 0.
// Reset sets trees in use to 15; the node table and features hold no reset value.
// The result cannot be held off and holds only until the next classify starts.
`timescale 1ns / 1ps
`default_nettype none
module forest_majority_vote_classifier_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  fmv_pkg::fmv_in_t             item,
	output logic                         busy,
	input  logic                         cfg_we,
	input  logic [fmv_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         done,
	output fmv_pkg::fmv_out_t            result
);
	import fmv_pkg::*;

	fmv_cmd_t    cmd;
	fmv_status_t status;

	fmv_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(item.action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	fmv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.status   (status),
		.done     (done),
		.result   (result)
	);

endmodule
`default_nettype wire

FILE: src/fmv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: src/fmv_ctrl.sv
// Controller state machine that sequences table writes, tree walks and the result.
`timescale 1ns / 1ps
`default_nettype none
module fmv_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fmv_pkg::ACTION_W-1:0]   action,
	input  fmv_pkg::fmv_status_t           status,
	output fmv_pkg::fmv_cmd_t              cmd,
	output logic                           busy
);
	import fmv_pkg::*;

	fmv_state_t state_q;
	fmv_state_t state_d;
	logic       tree_end;

	assign tree_end = status.node_leaf || status.depth_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && action == ACT_CLASSIFY) begin
					state_d = status.no_trees ? ST_FINISH : ST_WALK;
				end
			end
			ST_WALK: begin
				if (tree_end && status.last_tree) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = SEL_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				// The root of the first tree is read while the transaction is accepted.
				if (start) begin
					cmd.node_we = (action == ACT_NODE_WRITE);
					cmd.feat_we = (action == ACT_FEAT_WRITE);
					cmd.init    = (action == ACT_CLASSIFY);
				end
			end
			ST_WALK: begin
				if (tree_end) begin
					cmd.tree_done = 1'b1;
					cmd.addr_sel  = SEL_NEXT_ROOT;
				end else begin
					cmd.step     = 1'b1;
					cmd.addr_sel = SEL_CHILD;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.node_we && !cmd.feat_we && !cmd.init)
		else $error("table write or new classify issued while busy");

	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |=> state_q == ST_IDLE)
		else $error("finish state not followed by idle");

endmodule
`default_nettype wire

FILE: src/fmv_dp.sv
// Datapath: node table, feature store, walk counters and vote tally.
`timescale 1ns / 1ps
`default_nettype none
module fmv_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fmv_pkg::fmv_in_t             item,
	input  fmv_pkg::fmv_cmd_t            cmd,
	input  logic                         cfg_we,
	input  logic [fmv_pkg::CFG_W-1:0]    cfg_wdata,
	output fmv_pkg::fmv_status_t         status,
	output logic                         done,
	output fmv_pkg::fmv_out_t            result
);
	import fmv_pkg::*;

	logic [CFG_W-1:0]          trees_q;
	logic [CNT_W-1:0]          ntrees_q;
	logic [TREE_W-1:0]         tree_q;
	logic [STEP_W-1:0]         steps_q;
	logic [VOTES_W-1:0]        votes_q [NUM_CLASSES];
	logic [LABEL_W-1:0]        best_q;
	logic [VOTES_W-1:0]        bestv_q;
	logic                      err_q;
	logic                      done_q;
	logic signed [VALUE_W-1:0] feat_q [NUM_FEATURES];

	fmv_node_t                 wnode;
	fmv_node_t                 node;
	logic [NODE_BITS-1:0]      rdata;
	logic [ADDR_W-1:0]         raddr;
	logic signed [VALUE_W-1:0] feat_val;
	logic [NODE_W-1:0]         child;
	logic [VOTES_W-1:0]        vote_next;
	logic                      better;

	assign wnode.feature_index = item.feature_index;
	assign wnode.threshold     = item.value;
	assign wnode.is_leaf       = item.is_leaf;
	assign wnode.class_label   = item.class_label;
	assign wnode.left_index    = item.left_index;
	assign wnode.right_index   = item.right_index;

	fmv_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_node_table (
		.clk  (clk),
		.we   (cmd.node_we),
		.waddr({item.tree_index, item.node_index}),
		.wdata(wnode),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign node     = fmv_node_t'(rdata);
	assign feat_val = feat_q[node.feature_index];
	// Left on a strictly smaller feature, otherwise right.
	assign child    = (feat_val < node.threshold) ? node.left_index : node.right_index;

	always_comb begin
		unique case (cmd.addr_sel)
			SEL_ZERO:      raddr = '0;
			SEL_CHILD:     raddr = {tree_q, child};
			SEL_NEXT_ROOT: raddr = {TREE_W'(tree_q + 1'b1), {NODE_W{1'b0}}};
			default:       raddr = '0;
		endcase
	end

	assign status.no_trees  = (trees_q == '0);
	assign status.node_leaf = node.is_leaf;
	assign status.depth_hit = (steps_q == STEP_W'(MAX_DEPTH));
	assign status.last_tree = ((CNT_W'(tree_q) + CNT_W'(1)) == ntrees_q);

	// The running best is kept as votes arrive, so no tally pass is needed.
	assign vote_next = votes_q[node.class_label] + VOTES_W'(1);
	assign better    = (vote_next > bestv_q) ||
	                   ((vote_next == bestv_q) && (node.class_label < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trees_q <= TREES_RESET;
		end else if (cfg_we) begin
			trees_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.feat_we) begin
			feat_q[item.feature_index] <= item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntrees_q <= '0;
			tree_q   <= '0;
			steps_q  <= '0;
			best_q   <= '0;
			bestv_q  <= '0;
			err_q    <= 1'b0;
			done_q   <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				votes_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.finish;
			if (cmd.init) begin
				if (int'(trees_q) > MAX_TREES) begin
					ntrees_q <= CNT_W'(MAX_TREES);
				end else begin
					ntrees_q <= CNT_W'(trees_q);
				end
				tree_q  <= '0;
				steps_q <= '0;
				best_q  <= '0;
				bestv_q <= '0;
				err_q   <= 1'b0;
				for (int i = 0; i < NUM_CLASSES; i++) begin
					votes_q[i] <= '0;
				end
			end else if (cmd.step) begin
				steps_q <= steps_q + STEP_W'(1);
			end else if (cmd.tree_done) begin
				steps_q <= '0;
				tree_q  <= TREE_W'(tree_q + 1'b1);
				if (node.is_leaf) begin
					votes_q[node.class_label] <= vote_next;
					if (better) begin
						best_q  <= node.class_label;
						bestv_q <= vote_next;
					end
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end

	assign done                   = done_q;
	assign result.predicted_label = best_q;
	assign result.winning_votes   = bestv_q;
	assign result.walk_error      = err_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_W'(MAX_DEPTH))
		else $error("walk step count passed the depth limit");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_votes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(bestv_q) <= ntrees_q)
		else $error("winning vote count exceeds trees in use");

endmodule
`default_nettype wire

FILE: tb/tb_forest_majority_vote_classifier_top.sv
// Self-checking testbench for the decision-forest majority-vote classifier.
`timescale 1ns / 1ps
module tb_forest_majority_vote_classifier_top;
	import fmv_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int IN_BITS = $bits(fmv_in_t);

	// Keeps a copy of the node table, features and tree count and predicts each vote.
	class forest_vote_scoreboard;
		fmv_node_t         nodes[TABLE_DEPTH];
		logic signed [31:0] features[NUM_FEATURES];
		logic [CFG_W-1:0]  trees_in_use;
		fmv_out_t          pending_votes[$];
		int                errors;

		function new();
			trees_in_use = TREES_RESET;
			errors = 0;
		endfunction

		function fmv_out_t majority_vote();
			int unsigned votes[NUM_CLASSES];
			int ntrees;
			int slot;
			int best;
			int bestv;
			bit err;
			fmv_node_t n;
			fmv_out_t res;
			ntrees = (trees_in_use > MAX_TREES) ? MAX_TREES : int'(trees_in_use);
			err = 1'b0;
			foreach (votes[c]) votes[c] = 0;
			for (int t = 0; t < ntrees; t++) begin
				slot = 0;
				for (int steps = 0; steps <= MAX_DEPTH; steps++) begin
					n = nodes[t * NODES_PER_TREE + slot];
					if (n.is_leaf) begin
						votes[n.class_label]++;
						break;
					end
					// A tree still at an inner node after the last allowed step casts no vote.
					if (steps == MAX_DEPTH) begin
						err = 1'b1;
						break;
					end
					if ($signed(features[n.feature_index]) < $signed(n.threshold))
						slot = int'(n.left_index);
					else
						slot = int'(n.right_index);
				end
			end
			best = 0;
			bestv = 0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				if (votes[c] > bestv) begin
					bestv = votes[c];
					best = c;
				end
			end
			res.predicted_label = LABEL_W'(best);
			res.winning_votes = VOTES_W'((bestv > 31) ? 31 : bestv);
			res.walk_error = err;
			return res;
		endfunction

		function void note_transaction(fmv_in_t it);
			fmv_node_t n;
			case (it.action)
				ACT_NODE_WRITE: begin
					n.feature_index = it.feature_index;
					n.threshold = it.value;
					n.is_leaf = it.is_leaf;
					n.class_label = it.class_label;
					n.left_index = it.left_index;
					n.right_index = it.right_index;
					nodes[int'(it.tree_index) * NODES_PER_TREE + int'(it.node_index)] = n;
				end
				ACT_FEAT_WRITE: features[it.feature_index] = it.value;
				ACT_CLASSIFY: pending_votes.insert(pending_votes.size(), majority_vote());
				default: ;
			endcase
		endfunction

		function void check_result(fmv_out_t got);
			fmv_out_t want;
			if (pending_votes.size() == 0) begin
				$display("%0t: unexpected result: label %0d votes %0d error %0b",
					$time, got.predicted_label, got.winning_votes, got.walk_error);
				errors++;
				return;
			end
			want = pending_votes.pop_front();
			if (got.predicted_label !== want.predicted_label) begin
				$display("%0t: predicted_label expected %0d actual %0d",
					$time, want.predicted_label, got.predicted_label);
				errors++;
			end
			if (got.winning_votes !== want.winning_votes) begin
				$display("%0t: winning_votes expected %0d actual %0d",
					$time, want.winning_votes, got.winning_votes);
				errors++;
			end
			if (got.walk_error !== want.walk_error) begin
				$display("%0t: walk_error expected %0b actual %0b",
					$time, want.walk_error, got.walk_error);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	fmv_in_t          item;
	logic             busy;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             done;
	fmv_out_t         result;

	forest_vote_scoreboard sb;
	int items_sent;
	int idle_pct;
	// Slots written so far in each tree; inner nodes only ever point at these.
	bit node_seen[MAX_TREES][NODES_PER_TREE];
	int seen_slots[MAX_TREES][$];

	forest_majority_vote_classifier_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic send_item(input fmv_in_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_transaction(it);
		if (it.action != ACT_UNUSED)
			items_sent++;
	endtask

	function automatic int pick_child(input int t, input int self);
		int idx;
		idx = $urandom_range(0, seen_slots[t].size());
		if (idx == seen_slots[t].size())
			return self;
		return seen_slots[t][idx];
	endfunction

	task automatic write_node(input int t, input int slot, input int feat,
			input logic [31:0] thr, input bit leaf, input int label,
			input int l, input int r);
		fmv_in_t it;
		it.action = ACT_NODE_WRITE;
		it.tree_index = TREE_W'(t);
		it.node_index = NODE_W'(slot);
		it.feature_index = FEAT_W'(feat);
		it.value = thr;
		it.is_leaf = leaf;
		it.class_label = LABEL_W'(label);
		it.left_index = NODE_W'(l);
		it.right_index = NODE_W'(r);
		if (!node_seen[t][slot]) begin
			node_seen[t][slot] = 1'b1;
			seen_slots[t].insert(seen_slots[t].size(), slot);
		end
		send_item(it);
	endtask

	task automatic send_action(input logic [ACTION_W-1:0] act, input int feat,
			input logic [31:0] val);
		fmv_in_t it;
		it = IN_BITS'({$urandom(), $urandom(), $urandom()});
		it.action = act;
		it.feature_index = FEAT_W'(feat);
		it.value = val;
		send_item(it);
	endtask

	// Builds a path from the root through fresh slots down to a leaf.
	task automatic build_chain();
		int t;
		int len;
		int base;
		int nxt;
		int slot;
		int l;
		int r;
		t = $urandom_range(0, MAX_TREES - 1);
		if ($urandom_range(0, 4) == 0)
			len = $urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 3);
		else
			len = $urandom_range(1, 6);
		base = $urandom_range(0, NODES_PER_TREE - 2);
		nxt = 1 + (base + len) % (NODES_PER_TREE - 1);
		write_node(t, nxt, $urandom_range(0, 7), $urandom(), 1'b1, $urandom_range(0, 15),
			$urandom_range(0, 1023), $urandom_range(0, 1023));
		for (int i = len - 1; i >= 0; i--) begin
			slot = (i == 0) ? 0 : 1 + (base + i) % (NODES_PER_TREE - 1);
			if (len > 6 || $urandom_range(0, 1) == 0) begin
				l = nxt;
				r = nxt;
			end else if ($urandom_range(0, 1) == 0) begin
				l = nxt;
				r = pick_child(t, slot);
			end else begin
				l = pick_child(t, slot);
				r = nxt;
			end
			write_node(t, slot, $urandom_range(0, 7), $urandom(), 1'b0,
				$urandom_range(0, 15), l, r);
			nxt = slot;
		end
	endtask

	task automatic random_node();
		int t;
		int slot;
		int feat;
		bit leaf;
		logic [31:0] thr;
		t = $urandom_range(0, MAX_TREES - 1);
		if (seen_slots[t].size() > 0 && $urandom_range(0, 1) == 0)
			slot = seen_slots[t][$urandom_range(0, seen_slots[t].size() - 1)];
		else
			slot = $urandom_range(0, NODES_PER_TREE - 1);
		feat = $urandom_range(0, NUM_FEATURES - 1);
		leaf = 1'($urandom_range(0, 1));
		thr = ($urandom_range(0, 3) == 0) ? sb.features[feat] : $urandom();
		if (leaf)
			write_node(t, slot, feat, thr, 1'b1, $urandom_range(0, 15),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
		else
			write_node(t, slot, feat, thr, 1'b0, $urandom_range(0, 15),
				pick_child(t, slot), pick_child(t, slot));
	endtask

	task automatic random_feature();
		logic [31:0] val;
		case ($urandom_range(0, 7))
			0: val = 32'h8000_0000;
			1: val = 32'h7fff_ffff;
			2: val = 32'h0;
			default: val = $urandom();
		endcase
		send_action(ACT_FEAT_WRITE, $urandom_range(0, NUM_FEATURES - 1), val);
	endtask

	// Config writes only happen with nothing in flight.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_votes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tree_count(input logic [CFG_W-1:0] n);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.trees_in_use = n;
	endtask

	task automatic random_phase(input int count);
		int first;
		int pick;
		first = items_sent;
		while (items_sent - first < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				build_chain();
			else if (pick < 50)
				random_node();
			else if (pick < 65)
				random_feature();
			else if (pick < 95)
				send_action(ACT_CLASSIFY, $urandom_range(0, 7), $urandom());
			else
				send_action(ACT_UNUSED, $urandom_range(0, 7), $urandom());
		end
	endtask

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] phase_trees[7];
		sb = new();
		items_sent = 0;
		idle_pct = 30;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Every feature and every root is written before the first classify.
		send_action(ACT_FEAT_WRITE, 0, 32'h8000_0000);
		send_action(ACT_FEAT_WRITE, 1, 32'h7fff_ffff);
		for (int f = 2; f < NUM_FEATURES; f++)
			send_action(ACT_FEAT_WRITE, f, $urandom());
		// Labels repeat every four trees, so the reset count of 15 gives a three-way tie.
		for (int t = 0; t < MAX_TREES; t++)
			write_node(t, 0, 0, 32'h0, 1'b1, t % 4, 0, 0);
		send_action(ACT_CLASSIFY, 0, 32'h0);

		// Feature equal to threshold goes right, to the top node slot.
		write_node(0, 1023, 7, 32'hffff_ffff, 1'b1, 15, 1023, 1023);
		write_node(0, 1, 0, 32'h0, 1'b1, 0, 0, 0);
		write_node(0, 0, 0, 32'h8000_0000, 1'b0, 0, 1, 1023);
		// A root that points at itself never reaches a leaf.
		write_node(1, 0, 1, 32'h7fff_ffff, 1'b0, 0, 0, 0);
		// Most negative feature against most positive threshold goes left.
		write_node(2, 5, 3, 32'h0, 1'b1, 15, 0, 0);
		write_node(2, 0, 0, 32'h7fff_ffff, 1'b0, 0, 5, 0);
		send_action(ACT_CLASSIFY, 0, 32'h0);
		send_item('1);
		send_action(ACT_CLASSIFY, 7, 32'hffff_ffff);

		phase_trees = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd0, 5'd16};
		phase_trees[5] = CFG_W'($urandom_range(0, 31));
		for (int p = 0; p < 7; p++) begin
			settle();
			set_tree_count(phase_trees[p]);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 30;
				default: idle_pct = 60;
			endcase
			if (p == 6)
				idle_pct = 0;
			random_phase((phase_trees[p] == 0) ? 60 : 170);
		end

		settle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_votes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
